// ===== rtl/core/buck_voltage_pid_pwm_unit_defines.svh =====
// Assertion macros for the buck voltage PID PWM unit.
`ifndef BUCK_VOLTAGE_PID_PWM_UNIT_DEFINES_SVH
`define BUCK_VOLTAGE_PID_PWM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BVPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvpp check failed");
`define BVPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvpp check failed");
`else
`define BVPP_ASSERT_IMPL(lbl, ante, cons)
`define BVPP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/bvpp_pkg.sv =====
// Types, constants and microcode table for the buck voltage PID PWM unit.
`default_nettype none
package bvpp_pkg;

  localparam int PC_W = 3;

  // multiplier operand selects
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_CAL   = 3'd1;
  localparam logic [2:0] MUL_B0    = 3'd2;
  localparam logic [2:0] MUL_B1    = 3'd3;
  localparam logic [2:0] MUL_B2    = 3'd4;
  localparam logic [2:0] MUL_BOOST = 3'd5;
  localparam logic [2:0] MUL_DUTY  = 3'd6;

  // datapath operations
  localparam logic [2:0] ALU_NOP   = 3'd0;
  localparam logic [2:0] ALU_ERR   = 3'd1;
  localparam logic [2:0] ALU_ACC   = 3'd2;
  localparam logic [2:0] ALU_DUTY  = 3'd3;
  localparam logic [2:0] ALU_BOOST = 3'd4;
  localparam logic [2:0] ALU_OUT   = 3'd5;

  // jump conditions
  localparam logic JC_NONE     = 1'b0;
  localparam logic JC_OUT_BUSY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_COEF_B0    = 3'd0;
  localparam logic [2:0] REG_COEF_B1    = 3'd1;
  localparam logic [2:0] REG_COEF_B2    = 3'd2;
  localparam logic [2:0] REG_MAX_DUTY   = 3'd3;
  localparam logic [2:0] REG_MIN_DUTY   = 3'd4;
  localparam logic [2:0] REG_CAL_GAIN   = 3'd5;
  localparam logic [2:0] REG_CAL_OFFSET = 3'd6;
  localparam logic [2:0] REG_BOOST_DUTY = 3'd7;

  localparam logic [15:0] RST_COEF_B0    = 16'd5203;
  localparam logic [15:0] RST_COEF_B1    = 16'hD7FA;  // -10246
  localparam logic [15:0] RST_COEF_B2    = 16'd5044;
  localparam logic [11:0] RST_MAX_DUTY   = 12'd4095;
  localparam logic [11:0] RST_MIN_DUTY   = 12'd0;
  localparam logic [12:0] RST_CAL_GAIN   = 13'd4096;
  localparam logic [12:0] RST_CAL_OFFSET = 13'd0;
  localparam logic [11:0] RST_BOOST_DUTY = 12'd3809;

  typedef struct packed {
    logic [15:0] coef_b0;
    logic [15:0] coef_b1;
    logic [15:0] coef_b2;
    logic [11:0] max_duty;
    logic [11:0] min_duty;
    logic [12:0] cal_gain;
    logic [12:0] cal_offset;
    logic [11:0] boost_duty;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic [2:0]      alu_op;
    logic            hist;
    logic            jmp_cond;
    logic [PC_W-1:0] jmp_tgt;
    logic            last;
  } ucw_t;

  typedef struct packed {
    logic exec;
    ucw_t uw;
  } seq_ctl_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{mul_sel: MUL_NONE, alu_op: ALU_NOP, hist: 1'b0, jmp_cond: JC_NONE,
          jmp_tgt: '0, last: 1'b0};
    case (pc)
      3'd0: w.mul_sel = MUL_CAL;
      3'd1: begin
        w.mul_sel = MUL_B1;
        w.alu_op  = ALU_ERR;
      end
      3'd2: begin
        w.mul_sel = MUL_B2;
        w.alu_op  = ALU_ACC;
      end
      3'd3: begin
        w.mul_sel = MUL_B0;
        w.alu_op  = ALU_ACC;
      end
      3'd4: begin
        w.alu_op = ALU_ACC;
        w.hist   = 1'b1;
      end
      3'd5: begin
        w.mul_sel = MUL_BOOST;
        w.alu_op  = ALU_DUTY;
      end
      3'd6: begin
        w.mul_sel = MUL_DUTY;
        w.alu_op  = ALU_BOOST;
      end
      3'd7: begin
        w.alu_op   = ALU_OUT;
        w.jmp_cond = JC_OUT_BUSY;
        w.jmp_tgt  = 3'd7;
        w.last     = 1'b1;
      end
      default: w.alu_op = ALU_NOP;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bvpp_sequencer.sv =====
// Microcode step counter with conditional jump for the PID PWM unit.
`default_nettype none
module bvpp_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_free,
  output logic                 busy,
  output bvpp_pkg::seq_ctl_t   ctl
);

  logic                       busy_r, busy_nxt;
  logic [bvpp_pkg::PC_W-1:0]  pc_r, pc_nxt;
  bvpp_pkg::ucw_t             uw;
  logic                       jump;

  always_comb begin
    uw   = bvpp_pkg::ucode(pc_r);
    jump = busy_r && (uw.jmp_cond == bvpp_pkg::JC_OUT_BUSY) && !out_free;
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (busy_r) begin
      if (jump) begin
        pc_nxt = uw.jmp_tgt;
      end else if (uw.last) begin
        busy_nxt = 1'b0;
        pc_nxt   = '0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end else if (in_fire) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  assign busy     = busy_r;
  assign ctl.exec = busy_r && !jump;
  assign ctl.uw   = uw;

endmodule
`default_nettype wire

// ===== rtl/core/bvpp_datapath.sv =====
// Shared multiplier, PID accumulator, clamp and output registers.
`default_nettype none
module bvpp_datapath #(
  parameter int TIMER_PERIOD = 27200
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [11:0]        in_adc_sample,
  input  logic [11:0]        in_target_voltage,
  input  logic               in_pwm_enable,
  input  bvpp_pkg::cfg_t     cfg,
  input  bvpp_pkg::seq_ctl_t ctl,
  input  logic               out_stall,
  output logic               out_free,
  output logic               out_valid,
  output logic [11:0]        out_buck_duty,
  output logic [15:0]        out_buck_compare,
  output logic [14:0]        out_adc_trigger_compare,
  output logic [15:0]        out_boost_compare
);

  localparam logic [15:0] PERIOD = TIMER_PERIOD[15:0];

  logic [11:0]        sample_r, target_r;
  logic               enable_r;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [16:0] mul_a, mul_b;
  logic [15:0]        err_r, prev_r, prev2_r;
  logic [15:0]        err_nxt;
  logic [31:0]        acc_r;
  logic [11:0]        duty_r, duty_nxt;
  logic [15:0]        boost_r;
  logic               out_valid_r;
  logic [11:0]        o_duty_r;
  logic [15:0]        o_buck_r, o_boost_r;
  logic [14:0]        o_trig_r;
  logic signed [14:0] vout;
  logic signed [23:0] sh, lim_max, lim_min, c1, c2;
  logic               do_op;

  assign do_op = ctl.exec;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.uw.mul_sel)
      bvpp_pkg::MUL_CAL: begin
        mul_a = $signed({5'd0, sample_r});
        mul_b = $signed({4'd0, cfg.cal_gain});
      end
      bvpp_pkg::MUL_B0: begin
        mul_a = $signed({err_r[15], err_r});
        mul_b = $signed({cfg.coef_b0[15], cfg.coef_b0});
      end
      bvpp_pkg::MUL_B1: begin
        mul_a = $signed({prev_r[15], prev_r});
        mul_b = $signed({cfg.coef_b1[15], cfg.coef_b1});
      end
      bvpp_pkg::MUL_B2: begin
        mul_a = $signed({prev2_r[15], prev2_r});
        mul_b = $signed({cfg.coef_b2[15], cfg.coef_b2});
      end
      bvpp_pkg::MUL_BOOST: begin
        mul_a = $signed({5'd0, cfg.boost_duty});
        mul_b = $signed({1'b0, PERIOD});
      end
      bvpp_pkg::MUL_DUTY: begin
        mul_a = $signed({5'd0, duty_r});
        mul_b = $signed({1'b0, PERIOD});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    vout = $signed({2'b00, prod_r[24:12]})
         + $signed({{2{cfg.cal_offset[12]}}, cfg.cal_offset});
    err_nxt = 16'($signed({4'd0, target_r}) - $signed({vout[14], vout}));
    sh      = $signed(acc_r[31:8]);
    lim_max = $signed({12'd0, cfg.max_duty});
    lim_min = $signed({12'd0, cfg.min_duty});
    c1      = (sh > lim_max) ? lim_max : sh;
    c2      = (c1 < lim_min) ? lim_min : c1;
    duty_nxt = enable_r ? c2[11:0] : cfg.min_duty;
  end

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_adc_sample;
      target_r <= in_target_voltage;
      enable_r <= in_pwm_enable;
    end
    if (do_op && ctl.uw.mul_sel != bvpp_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (do_op) begin
      case (ctl.uw.alu_op)
        bvpp_pkg::ALU_ERR:   err_r   <= err_nxt;
        bvpp_pkg::ALU_DUTY:  duty_r  <= duty_nxt;
        bvpp_pkg::ALU_BOOST: boost_r <= PERIOD - prod_r[27:12];
        bvpp_pkg::ALU_OUT: begin
          o_duty_r  <= duty_r;
          o_buck_r  <= prod_r[27:12];
          o_trig_r  <= prod_r[27:13];
          o_boost_r <= boost_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      prev_r      <= '0;
      prev2_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_op && ctl.uw.alu_op == bvpp_pkg::ALU_ACC) begin
        acc_r <= acc_r + prod_r[31:0];
      end
      if (do_op && ctl.uw.hist) begin
        prev2_r <= prev_r;
        prev_r  <= err_r;
      end
      if (do_op && ctl.uw.alu_op == bvpp_pkg::ALU_OUT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_buck_duty           = o_duty_r;
  assign out_buck_compare        = o_buck_r;
  assign out_adc_trigger_compare = o_trig_r;
  assign out_boost_compare       = o_boost_r;

endmodule
`default_nettype wire

// ===== rtl/core/buck_voltage_pid_pwm_unit.sv =====
// Top level of the buck voltage PID PWM unit: configuration registers and glue.
`default_nettype none
`include "buck_voltage_pid_pwm_unit_defines.svh"
// Each sample transfer runs an 8-step microcode program on one shared
// 17x17 multiplier: calibration, three PID coefficient products into the
// wrapping 32-bit accumulator, duty clamp, boost compare and buck compare.
// A new sample is accepted in the cycle after the program ends, so a sample
// is not taken before the last one is through. in_stall is high while the
// program runs. The last step waits while the output register holds an
// untaken result; the output register lets the next sample enter while a
// result is still pending.
module buck_voltage_pid_pwm_unit #(
  parameter int TIMER_PERIOD = 27200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_adc_sample,
  input  logic [11:0] in_target_voltage,
  input  logic        in_pwm_enable,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_buck_duty,
  output logic [15:0] out_buck_compare,
  output logic [14:0] out_adc_trigger_compare,
  output logic [15:0] out_boost_compare
);

  bvpp_pkg::cfg_t     cfg_r;
  bvpp_pkg::seq_ctl_t ctl;
  logic               busy;
  logic               out_free;
  logic               in_fire;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_b0    <= bvpp_pkg::RST_COEF_B0;
      cfg_r.coef_b1    <= bvpp_pkg::RST_COEF_B1;
      cfg_r.coef_b2    <= bvpp_pkg::RST_COEF_B2;
      cfg_r.max_duty   <= bvpp_pkg::RST_MAX_DUTY;
      cfg_r.min_duty   <= bvpp_pkg::RST_MIN_DUTY;
      cfg_r.cal_gain   <= bvpp_pkg::RST_CAL_GAIN;
      cfg_r.cal_offset <= bvpp_pkg::RST_CAL_OFFSET;
      cfg_r.boost_duty <= bvpp_pkg::RST_BOOST_DUTY;
    end else if (cfg_we) begin
      case (cfg_index)
        bvpp_pkg::REG_COEF_B0:    cfg_r.coef_b0    <= cfg_wdata;
        bvpp_pkg::REG_COEF_B1:    cfg_r.coef_b1    <= cfg_wdata;
        bvpp_pkg::REG_COEF_B2:    cfg_r.coef_b2    <= cfg_wdata;
        bvpp_pkg::REG_MAX_DUTY:   cfg_r.max_duty   <= cfg_wdata[11:0];
        bvpp_pkg::REG_MIN_DUTY:   cfg_r.min_duty   <= cfg_wdata[11:0];
        bvpp_pkg::REG_CAL_GAIN:   cfg_r.cal_gain   <= cfg_wdata[12:0];
        bvpp_pkg::REG_CAL_OFFSET: cfg_r.cal_offset <= cfg_wdata[12:0];
        bvpp_pkg::REG_BOOST_DUTY: cfg_r.boost_duty <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  bvpp_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .busy     (busy),
    .ctl      (ctl)
  );

  bvpp_datapath #(
    .TIMER_PERIOD (TIMER_PERIOD)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_fire                 (in_fire),
    .in_adc_sample           (in_adc_sample),
    .in_target_voltage       (in_target_voltage),
    .in_pwm_enable           (in_pwm_enable),
    .cfg                     (cfg_r),
    .ctl                     (ctl),
    .out_stall               (out_stall),
    .out_free                (out_free),
    .out_valid               (out_valid),
    .out_buck_duty           (out_buck_duty),
    .out_buck_compare        (out_buck_compare),
    .out_adc_trigger_compare (out_adc_trigger_compare),
    .out_boost_compare       (out_boost_compare)
  );

  `BVPP_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `BVPP_ASSERT_NEXT(a_result_on_commit, ctl.exec && ctl.uw.alu_op == bvpp_pkg::ALU_OUT, out_valid)
  `BVPP_ASSERT_IMPL(a_boost_in_period, out_valid, out_boost_compare <= TIMER_PERIOD[15:0])

endmodule
`default_nettype wire
